@@ design/bsev_pkg.sv @@
package bsev_pkg;

  localparam int DefMaxBreaks = 64;
  localparam int DefMaxOrder  = 8;
  localparam int DefFracBits  = 16;
  localparam int WeightDepth  = 128;

  localparam int OrderW = 4;
  localparam int CountW = 7;
  localparam int CfgW   = 7;

  localparam logic [OrderW-1:0] ORDER_RESET = 4'd4;
  localparam logic [CountW-1:0] COUNT_RESET = 7'd2;

  typedef enum logic [1:0] {
    FUNC_WR_BREAK  = 2'd0,
    FUNC_WR_WEIGHT = 2'd1,
    FUNC_EVAL      = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  typedef enum logic {
    REG_ORDER = 1'b0,
    REG_COUNT = 1'b1
  } reg_e;

  // control between the sequencer and the omega divider
  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [32:0] den;
  } div_req_t;

endpackage

@@ design/bspline_evaluator.sv @@
// B-spline evaluator, Cox-de Boor recursion on a clamped knot vector.
// Input words on s_axis: tuser carries the function (write break point,
// write weight, evaluate), tdata the table index, the value written and the
// point x. Every input word gives exactly one output word on m_axis.
// Config port: cfg_we_i writes spline order (index 0) or break count
// (index 1); write only while the block is idle.
// A write goes from the idle state straight to the emit state. An evaluation
// with k = n + 2*(order-1) knots sweeps the basis memory level by level: the
// first level sets each basis function from its knot interval, and each one
// of a higher level takes up to two serial omega divisions of FRAC_BITS steps
// each, then the accumulation runs AC0, AC1 and AC2 per weight. One item is
// in flight at a time; s_axis_tready is high only while the sequencer idles.
// The output register holds a finished word while m_axis_tready is low; the
// block then waits before loading the next one. Reset sets order 4 and
// break count 2; tables are undefined until written.
module bspline_evaluator #(
  parameter int MAX_BREAKS = bsev_pkg::DefMaxBreaks,
  parameter int MAX_ORDER  = bsev_pkg::DefMaxOrder,
  parameter int FRAC_BITS  = bsev_pkg::DefFracBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // entry_index[6:0], entry_value[38:7], eval_point[70:39], zero pad
  input  logic [71:0]             s_axis_tdata,
  // func[1:0]
  input  logic [1:0]              s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // spline_value[31:0], saturated[32], bad_index[33], zero pad
  output logic [39:0]             m_axis_tdata,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [bsev_pkg::CfgW-1:0] cfg_data_i
);
  import bsev_pkg::*;

  localparam int KnotMax = MAX_BREAKS + 2 * (MAX_ORDER - 1);
  localparam int BA = $clog2(MAX_BREAKS);
  localparam int KA = $clog2(KnotMax);
  localparam int KW = $clog2(KnotMax + 1);
  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int BW = FRAC_BITS + 1;
  localparam int WA = $clog2(WeightDepth);
  localparam logic [BW-1:0] One = BW'(1) << FRAC_BITS;
  localparam logic signed [64:0] AccLim = 65'sd1 <<< 62;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_RD0   = 16'h0002,
    S_RD1   = 16'h0004,
    S_RD2   = 16'h0008,
    S_RD3   = 16'h0010,
    S_RD4   = 16'h0020,
    S_OM    = 16'h0040,
    S_DWAIT = 16'h0080,
    S_MUL   = 16'h0100,
    S_WR    = 16'h0200,
    S_AC0   = 16'h0400,
    S_AC1   = 16'h0800,
    S_AC2   = 16'h1000,
    S_FIN   = 16'h2000,
    S_EMIT  = 16'h4000,
    S_SPARE = 16'h8000
  } state_e;

  state_e state_q, state_d;

  logic [OrderW-1:0] cfg_order_q;
  logic [CountW-1:0] cfg_count_q;
  logic [KW-1:0]     i_q;
  logic [OW-1:0]     o_q;
  logic              sel_q;
  logic              m_valid_q;
  logic [39:0]       m_data_q;

  logic signed [31:0] x_q, ka0_q, ka1_q, kb0_q, kb1_q;
  logic [BW-1:0]      b0_q, b1_q, om0_q, om1_q;
  logic [2*BW-1:0]    p0_q, p1_q;
  logic signed [63:0] prod_q, acc_q;
  logic [31:0]        res_val_q;
  logic               res_sat_q, res_bad_q;

  // effective configuration
  int ord_i, n_i, deg_i, k_i, nb_i, ii, oi;
  always_comb begin
    ord_i = int'(cfg_order_q);
    if (ord_i < 1) ord_i = 1;
    if (ord_i > MAX_ORDER) ord_i = MAX_ORDER;
    n_i = int'(cfg_count_q);
    if (n_i < 2) n_i = 2;
    if (n_i > MAX_BREAKS) n_i = MAX_BREAKS;
    deg_i = ord_i - 1;
    k_i   = n_i + 2 * deg_i;
    nb_i  = k_i - ord_i;
    ii    = int'(i_q);
    oi    = int'(o_q);
  end

  function automatic logic [BA-1:0] knot_addr(input int j, input int deg, input int n);
    int m;
    logic [31:0] a;
    m = j - deg;
    if (j < deg) m = 0;
    else if (m >= n) m = n - 1;
    a = 32'(m);
    return a[BA-1:0];
  endfunction

  // input unpacking
  func_e        in_func;
  logic [6:0]   in_idx;
  logic [31:0]  in_val;
  logic [31:0]  in_x;
  logic         in_acc;
  logic [31:0]  in_idx_ext;
  assign in_func    = func_e'(s_axis_tuser[1:0]);
  assign in_idx     = s_axis_tdata[6:0];
  assign in_val     = s_axis_tdata[38:7];
  assign in_x       = s_axis_tdata[70:39];
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign in_idx_ext = 32'(in_idx);
  assign s_axis_tready = (state_q == S_IDLE);

  // memories
  logic           brk_we, wgt_we, bas_we;
  logic [BA-1:0]  brk_raddr;
  logic [31:0]    brk_rdata, wgt_rdata;
  logic [KA-1:0]  bas_raddr, bas_waddr;
  logic [BW-1:0]  bas_wdata, bas_rdata;
  logic [WA-1:0]  wgt_raddr;
  logic [31:0]    i_ext, i1_ext;

  assign i_ext  = 32'(i_q);
  assign i1_ext = 32'(i_q) + 32'd1;
  assign brk_we = in_acc && (in_func == FUNC_WR_BREAK) && (in_idx_ext < 32'(MAX_BREAKS));
  assign wgt_we = in_acc && (in_func == FUNC_WR_WEIGHT);

  always_comb begin
    case (state_q)
      S_RD1:   brk_raddr = knot_addr(ii + 1, deg_i, n_i);
      S_RD2:   brk_raddr = knot_addr(ii + oi - 1, deg_i, n_i);
      S_RD3:   brk_raddr = knot_addr(ii + oi, deg_i, n_i);
      default: brk_raddr = knot_addr(ii, deg_i, n_i);
    endcase
    bas_raddr = (state_q == S_RD1) ? i1_ext[KA-1:0] : i_ext[KA-1:0];
    wgt_raddr = i_ext[WA-1:0];
  end

  logic [31:0] brk_waddr_ext;
  assign brk_waddr_ext = in_idx_ext;

  bsev_ram #(.WIDTH(32), .DEPTH(MAX_BREAKS)) u_brk_ram (
    .clk_i  (clk_i),
    .we_i   (brk_we),
    .waddr_i(brk_waddr_ext[BA-1:0]),
    .wdata_i(in_val),
    .raddr_i(brk_raddr),
    .rdata_o(brk_rdata)
  );

  bsev_ram #(.WIDTH(32), .DEPTH(WeightDepth)) u_wgt_ram (
    .clk_i  (clk_i),
    .we_i   (wgt_we),
    .waddr_i(in_idx[WA-1:0]),
    .wdata_i(in_val),
    .raddr_i(wgt_raddr),
    .rdata_o(wgt_rdata)
  );

  bsev_ram #(.WIDTH(BW), .DEPTH(KnotMax)) u_bas_ram (
    .clk_i  (clk_i),
    .we_i   (bas_we),
    .waddr_i(bas_waddr),
    .wdata_i(bas_wdata),
    .raddr_i(bas_raddr),
    .rdata_o(bas_rdata)
  );

  // omega selection and divider
  logic signed [31:0] om_a, om_b;
  logic signed [32:0] num_s, den_s;
  logic               om_zero, om_one;
  div_req_t           div_req;
  logic               div_done;
  logic [FRAC_BITS-1:0] div_quo;

  assign om_a    = sel_q ? ka1_q : ka0_q;
  assign om_b    = sel_q ? kb1_q : kb0_q;
  assign num_s   = 33'(x_q) - 33'(om_a);
  assign den_s   = 33'(om_b) - 33'(om_a);
  assign om_zero = !(om_a < om_b) || (x_q <= om_a);
  assign om_one  = x_q >= om_b;

  assign div_req.start = (state_q == S_OM) && !om_zero && !om_one;
  assign div_req.num   = num_s;
  assign div_req.den   = den_s;

  bsev_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quo_o (div_quo)
  );

  logic om_fin;
  logic [BW-1:0] om_val;
  always_comb begin
    om_fin = 1'b0;
    om_val = '0;
    if (state_q == S_OM) begin
      om_fin = om_zero || om_one;
      om_val = om_zero ? '0 : One;
    end else if (state_q == S_DWAIT) begin
      om_fin = div_done;
      om_val = BW'(div_quo);
    end
  end

  // basis update
  logic [BW:0]   t_sum;
  logic          base_hit;
  logic          lvl_more, ord_more;
  assign t_sum     = (BW+1)'(p0_q >> FRAC_BITS) + (BW+1)'(p1_q >> FRAC_BITS);
  assign base_hit  = (ka0_q <= x_q) && (x_q < ka1_q);
  assign bas_we    = (state_q == S_WR);
  assign bas_waddr = i_ext[KA-1:0];
  assign bas_wdata = (oi == 1) ? (base_hit ? One : '0)
                               : ((t_sum > (BW+1)'(One)) ? One : t_sum[BW-1:0]);
  assign lvl_more  = (ii + 1 + oi) < k_i;
  assign ord_more  = oi < ord_i;

  // accumulation
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_sh;
  logic signed [31:0] w_use;
  assign w_use   = (i_ext < 32'(WeightDepth)) ? wgt_rdata : 32'sd0;
  assign acc_sum = 65'(acc_q) + 65'(prod_q);
  assign acc_sh  = acc_q >>> FRAC_BITS;

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = (in_func == FUNC_EVAL) ? S_RD0 : S_EMIT;
      S_RD0:   state_d = S_RD1;
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_RD3;
      S_RD3:   state_d = S_RD4;
      S_RD4:   state_d = (oi == 1) ? S_WR : S_OM;
      S_OM: begin
        if (div_req.start) state_d = S_DWAIT;
        else if (sel_q) state_d = S_MUL;
      end
      S_DWAIT: if (div_done) state_d = sel_q ? S_MUL : S_OM;
      S_MUL:   state_d = S_WR;
      S_WR:    state_d = (lvl_more || ord_more) ? S_RD0 : S_AC0;
      S_AC0:   state_d = S_AC1;
      S_AC1:   state_d = S_AC2;
      S_AC2:   state_d = (ii + 1 < nb_i) ? S_AC0 : S_FIN;
      S_FIN:   state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_order_q <= ORDER_RESET;
      cfg_count_q <= COUNT_RESET;
      i_q         <= '0;
      o_q         <= '0;
      sel_q       <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_ORDER: cfg_order_q <= cfg_data_i[OrderW-1:0];
          REG_COUNT: cfg_count_q <= cfg_data_i[CountW-1:0];
          default:   ;
        endcase
      end
      if (state_q == S_IDLE) begin
        i_q <= '0;
        o_q <= OW'(1);
      end
      if (state_q == S_RD4) sel_q <= 1'b0;
      if (om_fin && !sel_q) sel_q <= 1'b1;
      if (state_q == S_WR) begin
        if (lvl_more) begin
          i_q <= i_q + 1'b1;
        end else begin
          i_q <= '0;
          if (ord_more) o_q <= o_q + 1'b1;
        end
      end
      if (state_q == S_AC2) i_q <= i_q + 1'b1;
      if (state_q == S_EMIT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q       <= in_x;
        acc_q     <= '0;
        res_val_q <= '0;
        res_sat_q <= 1'b0;
        res_bad_q <= ((in_func == FUNC_WR_BREAK) && !(in_idx_ext < 32'(MAX_BREAKS)))
                  || ((in_func == FUNC_WR_WEIGHT) && !(in_idx_ext < 32'(WeightDepth)));
      end
      S_RD1: begin
        ka0_q <= brk_rdata;
        b0_q  <= bas_rdata;
      end
      S_RD2: begin
        ka1_q <= brk_rdata;
        b1_q  <= bas_rdata;
      end
      S_RD3:  kb0_q <= brk_rdata;
      S_RD4:  kb1_q <= brk_rdata;
      S_MUL: begin
        p0_q <= om0_q * b0_q;
        p1_q <= (One - om1_q) * b1_q;
      end
      S_AC1:  prod_q <= 64'($signed({1'b0, bas_rdata}) * w_use);
      S_AC2: begin
        if (acc_sum > AccLim) acc_q <= 64'(AccLim);
        else if (acc_sum < -AccLim) acc_q <= 64'(-AccLim);
        else acc_q <= acc_sum[63:0];
      end
      S_FIN: begin
        // floor to Q.F, then clip to the 32-bit range
        if (acc_sh > 64'sd2147483647) begin
          res_val_q <= 32'h7fff_ffff;
          res_sat_q <= 1'b1;
        end else if (acc_sh < -64'sd2147483648) begin
          res_val_q <= 32'h8000_0000;
          res_sat_q <= 1'b1;
        end else begin
          res_val_q <= acc_sh[31:0];
        end
      end
      S_EMIT: if (out_free) m_data_q <= {6'b0, res_bad_q, res_sat_q, res_val_q};
      default: ;
    endcase
    if (om_fin) begin
      if (sel_q) om1_q <= om_val;
      else om0_q <= om_val;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> state_q == S_DWAIT)
    else $error("divider started outside omega step");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33]) |-> (m_axis_tdata[32:0] == 33'd0))
    else $error("bad index word carries data");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[32]) |->
      (m_axis_tdata[31:0] == 32'h7fff_ffff || m_axis_tdata[31:0] == 32'h8000_0000))
    else $error("saturated word not at a rail");

  a_acc_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (65'(acc_q) <= AccLim && 65'(acc_q) >= -AccLim))
    else $error("accumulator out of range");

endmodule

@@ design/bsev_ram.sv @@
module bsev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/bsev_div.sv @@
module bsev_div #(
  parameter int FRAC_BITS = bsev_pkg::DefFracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bsev_pkg::div_req_t   req_i,
  output logic                 done_o,
  output logic [FRAC_BITS-1:0] quo_o
);
  import bsev_pkg::*;

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [32:0]   rem_q;
  logic [32:0]   den_q;
  logic [33:0]   rem2;
  logic          ge;

  // num < den on entry, so FRAC_BITS restoring steps give the whole quotient
  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(FRAC_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      den_q <= req_i.den;
      quo_o <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 33'(rem2 - {1'b0, den_q}) : rem2[32:0];
      quo_o <= {quo_o[FRAC_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;

endmodule

@@ tb/sv/tb_bspline_evaluator.sv @@
`timescale 1ns / 1ps

module tb_bspline_evaluator;
  import bsev_pkg::*;

  localparam int  MaxBreaks = DefMaxBreaks;
  localparam int  MaxOrder  = DefMaxOrder;
  localparam int  Frac      = DefFracBits;
  localparam int  KnotMax   = MaxBreaks + 2 * (MaxOrder - 1);
  localparam longint unsigned One = 64'd1 << Frac;
  localparam longint AccLimit = 64'sd1 <<< 62;
  localparam int  NPhase = 10;
  localparam int  NDir   = 23;

  typedef struct {
    logic [31:0] value;
    logic        sat;
    logic        bad;
  } result_t;

  typedef struct {
    func_e       func;
    logic [6:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    bit          typed;
    result_t     res;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  bspline_evaluator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow of the block state
  logic [3:0]  cur_order;
  logic [6:0]  cur_count;
  logic [31:0] break_mem [MaxBreaks];
  logic [31:0] weight_mem [WeightDepth];

  result_t spline_q [$];
  int  err_cnt;
  int  words_in;
  int  words_out;
  int  evals_done;
  int  sat_seen;
  int  bad_seen;
  int  press_hold;
  bit  no_idle;
  int  rx_gap;
  longint knot_lo;
  longint knot_hi;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(400_000_000);
    $display("timeout with %0d words still expected", spline_q.size());
    $display("tb_bspline_evaluator NOT OK");
    $finish;
  end

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned omega(longint x, longint a, longint b);
    if (!(a < b) || x <= a) return 0;
    if (x >= b) return One;
    return longint'(unsigned'((x - a) <<< Frac)) / longint'(b - a);
  endfunction

  function automatic result_t spline_at(logic [31:0] xv);
    longint kn [KnotMax];
    longint unsigned bas [KnotMax];
    longint unsigned om0, om1, t;
    longint x, acc, res, w;
    int ord, n, deg, k, nb, idx;
    result_t r;
    x   = sx32(xv);
    ord = (cur_order < 1) ? 1 : (cur_order > MaxOrder ? MaxOrder : int'(cur_order));
    n   = (cur_count < 2) ? 2 : (cur_count > MaxBreaks ? MaxBreaks : int'(cur_count));
    deg = ord - 1;
    k   = n + 2 * deg;
    for (int i = 0; i < k; i++) begin
      idx = (i < deg) ? 0 : ((i - deg < n) ? i - deg : n - 1);
      kn[i] = sx32(break_mem[idx]);
    end
    for (int i = 0; i + 1 < k; i++)
      bas[i] = (kn[i] <= x && x < kn[i+1]) ? One : 0;
    for (int o = 2; o <= ord; o++) begin
      for (int i = 0; i + o < k; i++) begin
        om0 = omega(x, kn[i], kn[i+o-1]);
        om1 = omega(x, kn[i+1], kn[i+o]);
        t = ((om0 * bas[i]) >> Frac) + (((One - om1) * bas[i+1]) >> Frac);
        bas[i] = (t > One) ? One : t;
      end
    end
    nb  = k - ord;
    acc = 0;
    for (int i = 0; i < nb; i++) begin
      w = (i < WeightDepth) ? sx32(weight_mem[i]) : 0;
      acc += longint'(bas[i]) * w;
      if (acc > AccLimit) acc = AccLimit;
      if (acc < -AccLimit) acc = -AccLimit;
    end
    if (acc >= 0) res = acc >>> Frac;
    else res = -((-acc + longint'(One) - 1) >>> Frac);
    r.sat = 1'b0;
    r.bad = 1'b0;
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      r.sat = 1'b1;
    end
    if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.value = res[31:0];
    return r;
  endfunction

  // update the shadow tables and return the word the block must answer with
  function automatic result_t apply_word(func_e f, logic [6:0] idx, logic [31:0] val,
                                         logic [31:0] x);
    result_t r;
    r = '{value: '0, sat: 1'b0, bad: 1'b0};
    case (f)
      FUNC_WR_BREAK: begin
        if (idx < MaxBreaks) break_mem[idx] = val;
        else r.bad = 1'b1;
      end
      FUNC_WR_WEIGHT: begin
        weight_mem[idx] = val;
      end
      FUNC_EVAL: begin
        r = spline_at(x);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_word(func_e f, logic [6:0] idx, logic [31:0] val, logic [31:0] x,
                           bit typed = 1'b0, result_t tres = '{'0, 1'b0, 1'b0});
    int gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {1'b0, x, val, idx};
    s_axis_tuser  <= f;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_word(f, idx, val, x);
    if (typed) r = tres;
    spline_q = {spline_q, r};
    words_in++;
    if (f == FUNC_EVAL) evals_done++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e r, int v);
    s_axis_tvalid <= 1'b0;
    while (spline_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    cfg_idx_i  <= r;
    cfg_data_i <= v[CfgW-1:0];
    cfg_we_i   <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (r == REG_ORDER) cur_order = v[3:0];
    else cur_count = v[6:0];
  endtask

  // sorted break points with some repeats, then every weight the sum reads
  task automatic load_tables();
    int n, nb, ord;
    longint b;
    logic [31:0] w;
    ord = (cur_order < 1) ? 1 : (cur_order > MaxOrder ? MaxOrder : int'(cur_order));
    n   = (cur_count < 2) ? 2 : (cur_count > MaxBreaks ? MaxBreaks : int'(cur_count));
    nb  = n + ord - 2;
    b   = longint'($urandom_range(0, 'h40000)) - 'h20000;
    knot_lo = b;
    for (int i = 0; i < n; i++) begin
      send_word(FUNC_WR_BREAK, i[6:0], b[31:0], '0);
      knot_hi = b;
      if ($urandom_range(4) != 0) b += $urandom_range(1, 'h30000);
    end
    for (int i = 0; i < nb; i++) begin
      w = ($urandom_range(3) == 0) ? $urandom : ($urandom_range(0, 'h80000) - 'h40000);
      send_word(FUNC_WR_WEIGHT, i[6:0], w, '0);
    end
  endtask

  task automatic random_words(int cnt);
    int r;
    int ix;
    longint x;
    for (int j = 0; j < cnt; j++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        if ($urandom_range(9) == 0) x = $signed($urandom);
        else if ($urandom_range(9) == 0) x = knot_hi;
        else x = knot_lo - 'h8000 + $urandom_range(0, int'(knot_hi - knot_lo) + 'h10000);
        send_word(FUNC_EVAL, 7'($urandom), $urandom, x[31:0]);
      end else if (r < 80) begin
        send_word(FUNC_WR_WEIGHT, 7'($urandom), $urandom, $urandom);
      end else if (r < 90) begin
        // nudge a break point, mostly keeping the order
        ix = $urandom_range(0, (cur_count < 2) ? 1 : (cur_count > 63 ? 63 : cur_count - 1));
        x = sx32(break_mem[ix]) + $urandom_range(0, 'h4000) - 'h2000;
        send_word(FUNC_WR_BREAK, ix[6:0], x[31:0], $urandom);
      end else if (r < 95) begin
        send_word(FUNC_NONE, 7'($urandom), $urandom, $urandom);
      end else begin
        send_word(FUNC_WR_BREAK, 7'($urandom_range(64, 127)), $urandom, $urandom);
      end
    end
  endtask

  // receiver with random hold-offs and a long back-pressure window on demand
  initial begin
    m_axis_tready = 1'b0;
    rx_gap = 0;
    forever begin
      @(negedge clk_i);
      if (press_hold > 0) begin
        m_axis_tready <= 1'b0;
        press_hold--;
      end else if (rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(9) < 3) rx_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (spline_q.size() == 0) begin
        $display("[%0t] unexpected output word %h", $time, m_axis_tdata);
        err_cnt++;
      end else begin
        e = spline_q.pop_front();
        if (m_axis_tdata[31:0] !== e.value)
          report_mismatch("spline_value", m_axis_tdata[31:0], e.value);
        if (m_axis_tdata[32] !== e.sat)
          report_mismatch("saturated", m_axis_tdata[32], e.sat);
        if (m_axis_tdata[33] !== e.bad)
          report_mismatch("bad_index", m_axis_tdata[33], e.bad);
        if (e.sat) sat_seen++;
        if (e.bad) bad_seen++;
      end
    end
  end

  initial begin
    row_t dir [NDir];
    result_t z, zb;
    int ph_ord [NPhase] = '{1, 2, 3, 4, 8, 5, 0, 15, 3, 8};
    int ph_cnt [NPhase] = '{2, 3, 5, 6, 4, 10, 0, 1, 127, 64};
    int ph_len [NPhase] = '{15, 25, 30, 35, 20, 20, 12, 12, 6, 3};

    z  = '{value: '0, sat: 1'b0, bad: 1'b0};
    zb = '{value: '0, sat: 1'b0, bad: 1'b1};
    // reset setting: order 4, two break points, four weights
    dir = '{
      '{FUNC_WR_BREAK,  7'd0,   32'h0000_0000, 32'h0, 1'b1, z},
      '{FUNC_WR_BREAK,  7'd1,   32'h0002_0000, 32'h0, 1'b1, z},
      '{FUNC_WR_WEIGHT, 7'd0,   32'h0001_0000, 32'h0, 1'b1, z},
      '{FUNC_WR_WEIGHT, 7'd1,   32'h7fff_ffff, 32'h0, 1'b1, z},
      '{FUNC_WR_WEIGHT, 7'd2,   32'h8000_0000, 32'h0, 1'b1, z},
      '{FUNC_WR_WEIGHT, 7'd3,   32'hffff_0000, 32'h0, 1'b1, z},
      '{FUNC_WR_BREAK,  7'd64,  32'h1234_5678, 32'h0, 1'b1, zb},
      '{FUNC_WR_BREAK,  7'd127, 32'hffff_ffff, 32'h0, 1'b1, zb},
      '{FUNC_WR_WEIGHT, 7'd127, 32'h0000_0000, 32'h0, 1'b1, z},
      '{FUNC_NONE,      7'd127, 32'hffff_ffff, 32'hffff_ffff, 1'b1, z},
      '{FUNC_EVAL,      7'd0,   32'h0, 32'h0002_0000, 1'b1, z},
      '{FUNC_EVAL,      7'd0,   32'h0, 32'h8000_0000, 1'b1, z},
      '{FUNC_EVAL,      7'd0,   32'h0, 32'h7fff_ffff, 1'b1, z},
      '{FUNC_EVAL,      7'd0,   32'h0, 32'h0000_0000, 1'b0, z},
      '{FUNC_EVAL,      7'd0,   32'h0, 32'h0001_0000, 1'b0, z},
      '{FUNC_EVAL,      7'd0,   32'h0, 32'h0000_0001, 1'b0, z},
      '{FUNC_WR_BREAK,  7'd1,   32'h0000_0000, 32'h0, 1'b1, z},
      '{FUNC_EVAL,      7'd0,   32'h0, 32'h0000_0000, 1'b0, z},
      '{FUNC_WR_BREAK,  7'd0,   32'h0003_0000, 32'h0, 1'b1, z},
      '{FUNC_EVAL,      7'd0,   32'h0, 32'h0001_0000, 1'b0, z},
      '{FUNC_WR_BREAK,  7'd0,   32'h8000_0000, 32'h0, 1'b1, z},
      '{FUNC_WR_BREAK,  7'd1,   32'h7fff_ffff, 32'h0, 1'b1, z},
      '{FUNC_EVAL,      7'd0,   32'h0, 32'h0000_0000, 1'b0, z}
    };

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_ORDER;
    cfg_data_i    = '0;
    err_cnt = 0;
    words_in = 0;
    words_out = 0;
    evals_done = 0;
    sat_seen = 0;
    bad_seen = 0;
    press_hold = 0;
    no_idle = 1'b0;
    cur_order = ORDER_RESET;
    cur_count = COUNT_RESET;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir[i])
      send_word(dir[i].func, dir[i].idx, dir[i].val, dir[i].x, dir[i].typed, dir[i].res);
    send_word(FUNC_EVAL, '0, '0, 32'h8000_0000);

    for (int p = 0; p < NPhase; p++) begin
      write_reg(REG_ORDER, ph_ord[p]);
      write_reg(REG_COUNT, ph_cnt[p]);
      no_idle = (p == 2);
      load_tables();
      // stall the output side so the block backs up its input
      if (p == 3) press_hold = 400;
      random_words(ph_len[p]);
    end

    s_axis_tvalid <= 1'b0;
    while (spline_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("%0d words in, %0d out, %0d evaluations over %0d order/count settings",
             words_in, words_out, evals_done, NPhase + 1);
    $display("%0d saturated sums, %0d rejected writes, %0d errors",
             sat_seen, bad_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_bspline_evaluator OK");
    end else begin
      $display("tb_bspline_evaluator NOT OK");
    end
    $finish;
  end

endmodule
